FILE: hw/rtl/otc_pkg.sv
// Shared types, codes and rectangle arithmetic for the object table unit.
package otc_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_MOVE_X  = 3'd1;
  localparam logic [2:0] REQ_MOVE_Y  = 3'd2;
  localparam logic [2:0] REQ_COLLIDE = 3'd3;
  localparam logic [2:0] REQ_HITS    = 3'd4;

  localparam logic [2:0] KIND_NONE          = 3'd0;
  localparam logic [2:0] KIND_PLAYER_TANK   = 3'd1;
  localparam logic [2:0] KIND_ENEMY_TANK    = 3'd2;
  localparam logic [2:0] KIND_OTHER_TANK    = 3'd3;
  localparam logic [2:0] KIND_BLOCK         = 3'd4;
  localparam logic [2:0] KIND_PLAYER_BULLET = 3'd5;
  localparam logic [2:0] KIND_ENEMY_BULLET  = 3'd6;
  localparam logic [2:0] KIND_FREE          = 3'd7;

  localparam logic [4:0] HIT_MAX = 5'd31;

  typedef struct packed {
    logic [2:0]         kind;
    logic [11:0]        h;
    logic [11:0]        w;
    logic signed [12:0] y;
    logic signed [12:0] x;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    logic       clear;
    logic       step;
    logic       count_mode;
    logic [2:0] want_kind;
  } scan_ctrl_t;

  // Inclusive-edge overlap on both axes.
  function automatic logic overlaps(rect_t a, rect_t b);
    logic signed [14:0] ax, ay, bx, by, axe, aye, bxe, bye;
    ax  = {{2{a.x[12]}}, a.x};
    ay  = {{2{a.y[12]}}, a.y};
    bx  = {{2{b.x[12]}}, b.x};
    by  = {{2{b.y[12]}}, b.y};
    axe = ax + {3'b000, a.w};
    aye = ay + {3'b000, a.h};
    bxe = bx + {3'b000, b.w};
    bye = by + {3'b000, b.h};
    return (ax <= bxe) && (axe >= bx) && (ay <= bye) && (aye >= by);
  endfunction

  // Add, clamp below at zero, then clamp above at extent minus size.
  function automatic logic signed [12:0] clamp_move(logic signed [12:0] pos,
                                                    logic [11:0] size,
                                                    logic signed [12:0] delta,
                                                    logic [11:0] extent);
    logic signed [13:0] sum, lim, p;
    sum = {pos[12], pos} + {delta[12], delta};
    lim = {2'b00, extent} - {2'b00, size};
    p   = (sum < 14'sd0) ? 14'sd0 : sum;
    if (p > lim) begin
      p = lim;
    end
    return p[12:0];
  endfunction

endpackage

FILE: hw/rtl/otc_table_ram.sv
// Object rectangle store: one write port, one read port with registered data.
module otc_table_ram
  import otc_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rect_t            wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output rect_t            rd_data
);

  logic [RECT_W-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= rect_t'(mem[rd_addr]);
  end

endmodule

FILE: hw/rtl/otc_scan.sv
// Per-entry overlap test and collision / hit accumulation during a table scan.
module otc_scan
  import otc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scan_ctrl_t ctrl,
  input  rect_t      subj,
  input  rect_t      cand,
  input  logic       cand_valid,
  input  logic       cand_self,
  output logic       collided,
  output logic [4:0] hit_count
);

  logic solid_kind;
  logic hit;

  assign solid_kind = (cand.kind == KIND_PLAYER_TANK) || (cand.kind == KIND_ENEMY_TANK) ||
                      (cand.kind == KIND_OTHER_TANK) || (cand.kind == KIND_BLOCK);

  always_comb begin
    if (ctrl.count_mode) begin
      hit = cand_valid && (cand.kind == ctrl.want_kind) && overlaps(subj, cand);
    end else begin
      hit = cand_valid && !cand_self && solid_kind && overlaps(subj, cand);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      collided  <= 1'b0;
      hit_count <= '0;
    end else if (ctrl.step && hit) begin
      if (ctrl.count_mode) begin
        // saturate the count
        if (hit_count != HIT_MAX) begin
          hit_count <= hit_count + 5'd1;
        end
      end else begin
        collided <= 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/object_table_clamped_move_and_collision_unit.sv
// Top level of the object table unit: request sequencer, output register, registers.
//
// The unit holds a table of object rectangles in a single-port-write, registered-read
// memory with valid bits in flip-flops cleared by reset. A request on the s_ side is
// taken only while the unit is idle and answers with exactly one result on the m_ side.
// A write is stored when it is accepted and then gives its result; a move or a request
// on an absent entry goes through read, modify and write back, then result. A collision
// test on a live entry, or a bullet count on a live player or enemy tank, also reads
// every table entry through the memory read port, one per cycle. A new request
// can be taken as soon as the result has been loaded into the output register.
// Registers extent_x (index 0) and extent_y (index 1) are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while the unit is idle, the block does not enforce it.
module object_table_clamped_move_and_collision_unit
  import otc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot[4:0], delta[17:5], load_x[30:18], load_y[43:31], load_w[55:44],
  // load_h[67:56], load_kind[70:68], zero pad[71]
  input  logic [71:0] s_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // new_position[12:0], collided[13], hit_count[18:14], zero pad[23:19]
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUBJ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic       CFG_WIDTH  = 1'b0;
  localparam logic       CFG_HEIGHT = 1'b1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]               state;
  logic [11:0]              extent_x;
  logic [11:0]              extent_y;
  logic [TABLE_ENTRIES-1:0] valid;

  logic [2:0]               req_q;
  logic [IDX_W-1:0]         slot_q;
  logic                     live_q;
  logic signed [12:0]       delta_q;
  logic [2:0]               want_q;
  logic [IDX_W-1:0]         scan_idx;
  rect_t                    subj;
  logic signed [12:0]       res_pos;

  logic signed [12:0]       out_pos;
  logic                     out_coll;
  logic [4:0]               out_hits;

  // request unpacking
  logic [2:0]         in_type;
  logic [4:0]         in_slot;
  logic signed [12:0] in_delta;
  rect_t              in_rect;
  logic [IDX_W-1:0]   in_idx;
  logic               in_range;
  logic               in_accept;

  assign in_type      = s_tuser;
  assign in_slot      = s_tdata[4:0];
  assign in_delta     = s_tdata[17:5];
  assign in_rect.x    = s_tdata[30:18];
  assign in_rect.y    = s_tdata[43:31];
  assign in_rect.w    = s_tdata[55:44];
  assign in_rect.h    = s_tdata[67:56];
  assign in_rect.kind = s_tdata[70:68];
  assign in_idx       = IDX_W'(in_slot);
  assign in_range     = 32'(in_slot) < TABLE_ENTRIES;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // memory ports and scan control
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rect_t            wr_data;
  logic [IDX_W-1:0] rd_addr;
  rect_t            rd_data;
  scan_ctrl_t       sc;
  logic             scan_coll;
  logic [4:0]       scan_hits;

  logic               is_move;
  logic signed [12:0] move_pos;
  rect_t              moved;
  logic [2:0]         want;
  logic               out_load;

  assign is_move = (req_q == REQ_MOVE_X) || (req_q == REQ_MOVE_Y);

  always_comb begin
    if (req_q == REQ_MOVE_X) begin
      move_pos = clamp_move(rd_data.x, rd_data.w, delta_q, extent_x);
    end else begin
      move_pos = clamp_move(rd_data.y, rd_data.h, delta_q, extent_y);
    end
    moved = rd_data;
    if (req_q == REQ_MOVE_X) begin
      moved.x = move_pos;
    end else begin
      moved.y = move_pos;
    end
  end

  always_comb begin
    case (rd_data.kind)
      KIND_ENEMY_TANK:  want = KIND_PLAYER_BULLET;
      KIND_PLAYER_TANK: want = KIND_ENEMY_BULLET;
      default:          want = KIND_NONE;
    endcase
  end

  always_comb begin
    rd_addr = in_idx;
    wr_en   = 1'b0;
    wr_addr = in_idx;
    wr_data = in_rect;
    sc      = '0;
    case (state)
      S_IDLE: begin
        wr_en = in_accept && (in_type == REQ_WRITE) && in_range;
      end
      S_SUBJ: begin
        rd_addr  = '0;
        sc.clear = 1'b1;
        wr_addr  = slot_q;
        wr_data  = moved;
        wr_en    = live_q && is_move;
      end
      S_SCAN: begin
        rd_addr       = scan_idx + 1'b1;
        sc.step       = 1'b1;
        sc.count_mode = (req_q == REQ_HITS);
        sc.want_kind  = want_q;
      end
      default: begin
      end
    endcase
  end

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  otc_table_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  otc_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sc),
    .subj       (subj),
    .cand       (rd_data),
    .cand_valid (valid[scan_idx]),
    .cand_self  (scan_idx == slot_q),
    .collided   (scan_coll),
    .hit_count  (scan_hits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      m_tvalid <= 1'b0;
      extent_x <= 12'd640;
      extent_y <= 12'd480;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  extent_x <= cfg_data;
          CFG_HEIGHT: extent_y <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            // entries leave the table when written as free
            if ((in_type == REQ_WRITE) && in_range) begin
              valid[in_idx] <= (in_rect.kind != KIND_FREE);
            end
            state <= S_SUBJ;
          end
        end
        S_SUBJ: begin
          scan_idx <= '0;
          if (live_q && ((req_q == REQ_COLLIDE) ||
                         ((req_q == REQ_HITS) && (want != KIND_NONE)))) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == LAST_IDX) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_q   <= in_type;
      slot_q  <= in_idx;
      delta_q <= in_delta;
      live_q  <= in_range && valid[in_idx];
    end
    if (state == S_SUBJ) begin
      subj    <= rd_data;
      want_q  <= want;
      res_pos <= (live_q && is_move) ? move_pos : 13'sd0;
    end
    if (out_load) begin
      out_pos  <= res_pos;
      out_coll <= scan_coll;
      out_hits <= scan_hits;
    end
  end

  assign m_tdata = {5'b00000, out_hits, out_coll, out_pos};

`ifndef SYNTHESIS
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_idx == LAST_IDX) |=> (state == S_DONE))
    else $error("scan did not end after the last entry");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && req_q != REQ_MOVE_X && req_q != REQ_MOVE_Y) |-> (res_pos == 13'sd0))
    else $error("nonzero position on a request that is not a move");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[13] && (m_tdata[18:14] != 5'd0)))
    else $error("collision flag and hit count both set");

  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_type == REQ_WRITE && in_range && in_rect.kind != KIND_FREE)
      |=> valid[slot_q])
    else $error("written entry not marked valid");
`endif

endmodule
